@@ design/snep_pkg.sv @@
package snep_pkg;

  // Line geometry: one slot is kept spare, so the line holds LINE_SLOTS-1 characters
  localparam int unsigned LINE_SLOTS = 16;
  localparam int unsigned LINE_CAP   = LINE_SLOTS - 1;
  localparam int unsigned CNT_W      = $clog2(LINE_CAP + 1);
  localparam int unsigned IDX_W      = $clog2(LINE_CAP);

  // Stored character codes: 0..9 digits, 10 leading minus
  localparam int unsigned     CODE_W     = 4;
  localparam logic [CODE_W-1:0] CODE_MINUS = 4'd10;

  // Field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned LEN_W   = 4;

  // Terminal characters
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_ESC   = 8'h1B;
  localparam logic [BYTE_W-1:0] CH_UP    = 8'h75;
  localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
  localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7F;

  // Result command codes
  typedef enum logic [1:0] {
    KIND_KEEP = 2'd0,
    KIND_DATA = 2'd1,
    KIND_UP   = 2'd2
  } snep_kind_e;

  // Operations on the character line
  typedef enum logic [2:0] {
    OP_IDLE,   // hold everything
    OP_KEEP,   // apply full-line trim only
    OP_DIGIT,  // append a digit
    OP_MINUS,  // leading minus if the line is empty
    OP_BACK,   // drop last character
    OP_CLEAR,  // empty the line
    OP_SHIFT   // move the line one slot toward the head
  } snep_op_e;

  typedef struct packed {
    snep_op_e          op;
    logic [CODE_W-1:0] code;
  } snep_line_ctrl_t;

  typedef struct packed {
    logic [CNT_W-1:0]  cnt_adj;   // count after full-line trim
    logic [CNT_W-1:0]  cnt_next;  // count after this operation
    logic [CODE_W-1:0] head;      // character at the head of the line
  } snep_line_stat_t;

endpackage

@@ design/snep_line.sv @@
module snep_line (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  snep_pkg::snep_line_ctrl_t ctrl_i,
  output snep_pkg::snep_line_stat_t stat_o
);
  import snep_pkg::*;

  logic [CODE_W-1:0] store_q [LINE_CAP];
  logic [CODE_W-1:0] store_d [LINE_CAP];
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  cnt_adj;

  // A full line loses its last character before each word is handled
  assign cnt_adj = (count_q >= CNT_W'(LINE_CAP)) ? CNT_W'(LINE_CAP - 1) : count_q;

  // Line update
  always_comb begin
    store_d = store_q;
    count_d = count_q;
    case (ctrl_i.op)
      OP_IDLE: begin
      end
      OP_KEEP: begin
        count_d = cnt_adj;
      end
      OP_DIGIT: begin
        store_d[cnt_adj[IDX_W-1:0]] = ctrl_i.code;
        count_d = cnt_adj + CNT_W'(1);
      end
      OP_MINUS: begin
        count_d = cnt_adj;
        if (cnt_adj == '0) begin
          store_d[0] = CODE_MINUS;
          count_d    = CNT_W'(1);
        end
      end
      OP_BACK: begin
        count_d = (cnt_adj != '0) ? cnt_adj - CNT_W'(1) : cnt_adj;
      end
      OP_CLEAR: begin
        count_d = '0;
      end
      OP_SHIFT: begin
        for (int i = 0; i < LINE_CAP - 1; i++) begin
          store_d[i] = store_q[i+1];
        end
      end
      default: begin
      end
    endcase
  end

  // Character slots carry no reset; only slots below the count are read
  always_ff @(posedge clk_i) begin
    store_q <= store_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign stat_o.cnt_adj  = cnt_adj;
  assign stat_o.cnt_next = count_d;
  assign stat_o.head     = store_q[0];

endmodule

@@ design/snep_conv.sv @@
module snep_conv (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic                                neg_i,
  input  logic                                step_i,
  input  logic [snep_pkg::CODE_W-1:0]         digit_i,
  output logic signed [snep_pkg::VALUE_W-1:0] value_o
);
  import snep_pkg::*;

  localparam int unsigned PROD_W = VALUE_W + 4;
  localparam logic [VALUE_W-1:0] LIMIT   = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic [VALUE_W-1:0] SAT_MAG = LIMIT + VALUE_W'(1);
  localparam logic [VALUE_W-1:0] POS_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

  logic [VALUE_W-1:0] mag_q, mag_d;
  logic               neg_q, skip_q;
  logic [PROD_W-1:0]  prod;

  // mag*10 + digit, clamped just above the signed range
  assign prod = (PROD_W'(mag_q) << 3) + (PROD_W'(mag_q) << 1) + PROD_W'(digit_i);

  always_comb begin
    mag_d = mag_q;
    if (start_i) begin
      mag_d = '0;
    end else if (step_i && !skip_q) begin
      mag_d = (prod > PROD_W'(LIMIT)) ? SAT_MAG : prod[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
  end

  // Sign flag; the minus sign is the first character walked and is skipped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neg_q  <= 1'b0;
      skip_q <= 1'b0;
    end else if (start_i) begin
      neg_q  <= neg_i;
      skip_q <= neg_i;
    end else if (step_i) begin
      skip_q <= 1'b0;
    end
  end

  // Final saturation and sign
  always_comb begin
    if (mag_q[VALUE_W-1]) begin
      value_o = neg_q ? signed'(LIMIT) : signed'(POS_MAX);
    end else begin
      value_o = neg_q ? signed'(VALUE_W'(0) - mag_q) : signed'(mag_q);
    end
  end

endmodule

@@ design/serial_numeric_entry_parser.sv @@
// Serial numeric entry parser.
// Input channel: one terminal byte per word on rx_byte_i (in_valid_i/in_ready_o).
// Output channel: one result word per input byte (out_valid_o/out_ready_i)
// carrying command_kind_o (keep, data, up), entered_value_o and line_length_o.
// Digits and a leading minus build a line of up to 14..15 characters;
// backspace or DEL drops one, Enter/CR converts it, ESC or 'u' goes up a level.
// An ordinary byte is latched into the input register; the execute step then
// loads its result word into the output register. Enter on a line that holds a
// digit passes the execute step, then the conversion step, which walks one
// stored character (minus included) per cycle through a single
// multiply-by-ten-and-add step, then the finish step, which loads the result;
// the full-line trim leaves at most 14 characters to walk.
// Each byte, a converting Enter included, holds the input until it is finished.
// A new byte is taken once the previous one is finished, even while its
// result still waits in the output register.
// A stalled receiver holds the output register; the next byte then waits in
// the input register until the output frees up.
// Reset empties the line and drops any pending result; no clearing pass.
module serial_numeric_entry_parser (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [snep_pkg::BYTE_W-1:0]         rx_byte_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          command_kind_o,
  output logic signed [snep_pkg::VALUE_W-1:0] entered_value_o,
  output logic [snep_pkg::LEN_W-1:0]          line_length_o
);
  import snep_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CONV,
    ST_FIN
  } state_e;

  state_e                      state_q, state_d;
  logic [BYTE_W-1:0]           byte_q, byte_d;
  logic [CNT_W-1:0]            remain_q, remain_d;
  logic                        out_valid_q, out_valid_d;
  snep_kind_e                  kind_q, kind_d;
  logic signed [VALUE_W-1:0]   value_q, value_d;
  logic [LEN_W-1:0]            len_q, len_d;

  snep_line_ctrl_t             line_ctrl;
  snep_line_stat_t             line_stat;
  logic                        conv_start, conv_step;
  logic signed [VALUE_W-1:0]   conv_value;

  logic is_digit, is_minus, is_enter, is_up, is_back;
  logic out_free, line_neg, has_digits;

  // Byte classes
  assign is_digit = (byte_q >= CH_ZERO) && (byte_q <= CH_NINE);
  assign is_minus = (byte_q == CH_MINUS);
  assign is_enter = (byte_q == CH_LF) || (byte_q == CH_CR);
  assign is_up    = (byte_q == CH_ESC) || (byte_q == CH_UP);
  assign is_back  = (byte_q == CH_BS) || (byte_q == CH_DEL);

  assign out_free   = !out_valid_q || out_ready_i;
  assign line_neg   = (line_stat.cnt_adj != '0) && (line_stat.head == CODE_MINUS);
  assign has_digits = line_stat.cnt_adj > CNT_W'(line_neg);

  // Sequencer and output register
  always_comb begin
    state_d        = state_q;
    byte_d         = byte_q;
    remain_d       = remain_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    kind_d         = kind_q;
    value_d        = value_q;
    len_d          = len_q;
    line_ctrl.op   = OP_IDLE;
    line_ctrl.code = byte_q[CODE_W-1:0] - CH_ZERO[CODE_W-1:0];
    conv_start     = 1'b0;
    conv_step      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          byte_d  = rx_byte_i;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          if (is_enter && has_digits) begin
            line_ctrl.op = OP_KEEP;
            conv_start   = 1'b1;
            remain_d     = line_stat.cnt_adj;
            state_d      = ST_CONV;
          end else begin
            if (is_digit) begin
              line_ctrl.op = OP_DIGIT;
            end else if (is_minus) begin
              line_ctrl.op = OP_MINUS;
            end else if (is_enter || is_up) begin
              line_ctrl.op = OP_CLEAR;
            end else if (is_back) begin
              line_ctrl.op = OP_BACK;
            end else begin
              line_ctrl.op = OP_KEEP;
            end
            out_valid_d = 1'b1;
            kind_d      = is_up ? KIND_UP : KIND_KEEP;
            value_d     = '0;
            len_d       = LEN_W'(line_stat.cnt_next);
            state_d     = ST_IDLE;
          end
        end
      end
      ST_CONV: begin
        // one stored character per cycle from the head of the line
        line_ctrl.op   = OP_SHIFT;
        line_ctrl.code = line_stat.head;
        conv_step      = 1'b1;
        remain_d       = remain_q - CNT_W'(1);
        if (remain_q == CNT_W'(1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        line_ctrl.op = OP_CLEAR;
        out_valid_d  = 1'b1;
        kind_d       = KIND_DATA;
        value_d      = conv_value;
        len_d        = '0;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      byte_q      <= '0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
      kind_q      <= KIND_KEEP;
      value_q     <= '0;
      len_q       <= '0;
    end else begin
      state_q     <= state_d;
      byte_q      <= byte_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
      kind_q      <= kind_d;
      value_q     <= value_d;
      len_q       <= len_d;
    end
  end

  snep_line u_line (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (line_ctrl),
    .stat_o (line_stat)
  );

  snep_conv u_conv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (conv_start),
    .neg_i   (line_neg),
    .step_i  (conv_step),
    .digit_i (line_stat.head),
    .value_o (conv_value)
  );

  assign in_ready_o      = (state_q == ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign command_kind_o  = kind_q;
  assign entered_value_o = value_q;
  assign line_length_o   = len_q;

`ifndef SYNTHESIS
  // Nothing loads the output register while digits are being walked
  a_conv_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CONV) |-> !out_valid_q)
    else $error("output register busy during conversion");

  // Conversion never runs with an exhausted character count
  a_conv_remain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CONV) |-> (remain_q != '0))
    else $error("conversion walked past the line");

  // Only a data command carries a value
  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (command_kind_o != KIND_DATA)) |-> (entered_value_o == '0))
    else $error("value on a non-data command");

  // Every data or up command leaves an empty line
  a_cmd_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (command_kind_o != KIND_KEEP)) |-> (line_length_o == '0))
    else $error("line not cleared by a command");

  // A result is loaded only from the execute or finish step
  a_load_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_EXEC || $past(state_q) == ST_FIN))
    else $error("result loaded from an unexpected step");
`endif

endmodule
